// ===== hdl/skt_pkg.sv =====
// shared types, codes and defaults for the sorted key table
package skt_pkg;

   localparam int CAPACITY_DEFAULT  = 256;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH       = 32;
   localparam int COUNT_OUT_WIDTH   = 9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic [FIELD_WIDTH-1:0]     found_size;
      logic [FIELD_WIDTH-1:0]     found_page;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
   } result_type;

endpackage

// ===== hdl/skt_cell_ram.sv =====
// cell storage: one write port, one registered read port
module skt_cell_ram #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 96,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data
);

   logic [DATA_WIDTH-1:0] cells_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/skt_ctrl.sv =====
// search and shift sequencer around one shared key comparator
module skt_ctrl #(
   parameter int CAPACITY   = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH  = skt_pkg::KEY_WIDTH_DEFAULT,
   parameter int DATA_WIDTH = KEY_WIDTH + 2 * skt_pkg::FIELD_WIDTH,
   parameter int ADDR_WIDTH = $clog2(CAPACITY)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                opcode,
   input  logic [KEY_WIDTH-1:0]                key,
   input  logic [skt_pkg::FIELD_WIDTH-1:0]     data_size,
   input  logic [skt_pkg::FIELD_WIDTH-1:0]     data_page,
   input  logic                                ack,
   output logic                                idle,
   output logic                                done,
   output skt_pkg::result_type                 result,
   output logic                                rd_en,
   output logic [ADDR_WIDTH-1:0]               rd_addr,
   input  logic [DATA_WIDTH-1:0]               rd_data,
   output logic                                wr_en,
   output logic [ADDR_WIDTH-1:0]               wr_addr,
   output logic [DATA_WIDTH-1:0]               wr_data
);
   import skt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_COMPARE, S_SHIFT, S_WRITE, S_DONE
   } state_type;

   state_type              state_ff;
   logic                   op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [FIELD_WIDTH-1:0] size_ff;
   logic [FIELD_WIDTH-1:0] page_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hi_ff;
   logic [CW-1:0]          mid_ff;
   logic [CW-1:0]          mid_in;
   logic [CW-1:0]          wptr_ff;
   status_type             status_ff;
   logic [FIELD_WIDTH-1:0] fsize_ff;
   logic [FIELD_WIDTH-1:0] fpage_ff;

   logic [KEY_WIDTH-1:0]   cell_key;
   logic                   key_lt;
   logic                   key_gt;
   logic [CW-1:0]          last_idx;
   logic [CW-1:0]          shift_src;

   assign mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_idx  = count_ff - CW'(1);
   assign shift_src = wptr_ff - CW'(2);
   assign cell_key  = rd_data[DATA_WIDTH-1 -: KEY_WIDTH];
   // the shared comparator
   assign key_lt    = key_ff < cell_key;
   assign key_gt    = cell_key < key_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = mid_in[ADDR_WIDTH-1:0];
      wr_en   = 1'b0;
      wr_addr = wptr_ff[ADDR_WIDTH-1:0];
      wr_data = rd_data;
      case (state_ff)
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en   = 1'b1;
               rd_addr = mid_in[ADDR_WIDTH-1:0];
            end else if (op_ff == OP_INSERT && lo_ff != count_ff) begin
               rd_en   = 1'b1;
               rd_addr = last_idx[ADDR_WIDTH-1:0];
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wptr_ff[ADDR_WIDTH-1:0];
            wr_data = rd_data;
            if (CW'(wptr_ff - CW'(1)) != lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = shift_src[ADDR_WIDTH-1:0];
            end
         end
         S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[ADDR_WIDTH-1:0];
            wr_data = {key_ff, size_ff, page_ff};
         end
         default: begin
            rd_en = 1'b0;
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= opcode;
                  key_ff   <= key;
                  size_ff  <= data_size;
                  page_ff  <= data_page;
                  fsize_ff <= '0;
                  fpage_ff <= '0;
                  lo_ff    <= '0;
                  hi_ff    <= count_ff;
                  if (opcode == OP_INSERT && count_ff >= CW'(CAPACITY)) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_SEARCH;
                  end
               end
            end
            S_SEARCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_COMPARE;
               end else if (op_ff == OP_LOOKUP) begin
                  status_ff <= ST_MISS;
                  state_ff  <= S_DONE;
               end else if (lo_ff == count_ff) begin
                  state_ff <= S_WRITE;
               end else begin
                  wptr_ff  <= count_ff;
                  state_ff <= S_SHIFT;
               end
            end
            S_COMPARE: begin
               if (key_lt) begin
                  hi_ff    <= mid_ff;
                  state_ff <= S_SEARCH;
               end else if (key_gt) begin
                  lo_ff    <= mid_ff + CW'(1);
                  state_ff <= S_SEARCH;
               end else begin
                  if (op_ff == OP_LOOKUP) begin
                     status_ff <= ST_OK;
                     fsize_ff  <= rd_data[2*FIELD_WIDTH-1:FIELD_WIDTH];
                     fpage_ff  <= rd_data[FIELD_WIDTH-1:0];
                  end else begin
                     status_ff <= ST_DUP;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_SHIFT: begin
               if (CW'(wptr_ff - CW'(1)) == lo_ff) begin
                  state_ff <= S_WRITE;
               end else begin
                  wptr_ff <= wptr_ff - CW'(1);
               end
            end
            S_WRITE: begin
               count_ff  <= count_ff + CW'(1);
               status_ff <= ST_OK;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign idle               = (state_ff == S_IDLE);
   assign done               = (state_ff == S_DONE);
   assign result.status      = status_ff;
   assign result.found_size  = fsize_ff;
   assign result.found_page  = fpage_ff;
   assign result.entry_count = COUNT_OUT_WIDTH'(count_ff);

endmodule

// ===== hdl/sorted_key_table.sv =====
// sorted key table: ordered cell store with binary-search insert and lookup
// accepting edge to result: a full-table insert goes straight to done; else a search and
// a compare state per probe (up to ceil(log2(n+1)) probes for n cells), one more search for
// a miss or fresh insert, for a fresh insert a shift moving each cell above the slot up by
// one, then a write; done waits for a free output register; one beat at a time, the next taken
// once the result is loaded; one ram read port, one key comparator; reset empties the table
module sorted_key_table #(
   parameter int CAPACITY  = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic [skt_pkg::FIELD_WIDTH-1:0]        req_key,
   input  logic [skt_pkg::FIELD_WIDTH-1:0]        req_data_size,
   input  logic [skt_pkg::FIELD_WIDTH-1:0]        req_data_page,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output skt_pkg::status_type                    rsp_status,
   output logic [skt_pkg::FIELD_WIDTH-1:0]        rsp_found_size,
   output logic [skt_pkg::FIELD_WIDTH-1:0]        rsp_found_page,
   output logic [skt_pkg::COUNT_OUT_WIDTH-1:0]    rsp_entry_count
);
   import skt_pkg::*;

   localparam int DATA_WIDTH = KEY_WIDTH + 2 * FIELD_WIDTH;
   localparam int ADDR_WIDTH = $clog2(CAPACITY);

   // key as stored: zero-extended then cut to the key width
   logic [2*FIELD_WIDTH-1:0] key_ext;
   logic [KEY_WIDTH-1:0]     key_masked;

   logic                  start;
   logic                  ctrl_idle;
   logic                  ctrl_done;
   logic                  load;
   result_type            ctrl_result;

   logic                  rd_en;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  wr_en;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // output beat register
   logic                  rsp_valid_ff;
   result_type            rsp_result_ff;

   assign key_ext    = {{FIELD_WIDTH{1'b0}}, req_key};
   assign key_masked = key_ext[KEY_WIDTH-1:0];

   // a new beat is taken whenever the sequencer is free, even with a result pending
   assign req_ready = ctrl_idle;
   assign start     = req_valid && req_ready;

   // move a finished result into the output register once it is empty or draining
   assign load = ctrl_done && (!rsp_valid_ff || rsp_ready);

   skt_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .opcode       (req_opcode),
      .key          (key_masked),
      .data_size    (req_data_size),
      .data_page    (req_data_page),
      .ack          (load),
      .idle         (ctrl_idle),
      .done         (ctrl_done),
      .result       (ctrl_result),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   skt_cell_ram #(
      .DEPTH      (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_result_ff <= ctrl_result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_result_ff.status;
   assign rsp_found_size  = rsp_result_ff.found_size;
   assign rsp_found_page  = rsp_result_ff.found_page;
   assign rsp_entry_count = rsp_result_ff.entry_count;

   // the sequencer is not ready again in the cycle after it takes a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous beat still in flight");

   // only a found lookup carries a size and page
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_found_size == '0 && rsp_found_page == '0))
      else $error("non-ok result carries size or page");

   // a full answer only comes from a table holding its capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == COUNT_OUT_WIDTH'(CAPACITY)))
      else $error("full status with table not at capacity");

endmodule
